// ===== design/crc8fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, constants and the byte-wide CRC-8 update for the framed
// packet receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

	// register indexes on the configuration port
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTE     = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_INFO_COMMAND    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MIN_INFO_LENGTH = 2'd2;

	// register reset values
	localparam logic [7:0] HEADER_BYTE_RST     = 8'h55;
	localparam logic [3:0] INFO_COMMAND_RST    = 4'h0;
	localparam logic [7:0] MIN_INFO_LENGTH_RST = 8'h01;

	// protocol constants
	localparam logic [3:0] CAMERA_DEVICE = 4'h2;
	localparam logic [7:0] CRC_POLY      = 8'h31;
	localparam logic [7:0] CRC_INIT      = 8'h00;

	// frame phase, one-hot
	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_COMMAND = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_DATA    = 5'b01000,
		PH_CRC     = 5'b10000
	} phase_t;

	// one byte through the crc, msb first, no reflection
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ===== design/crc8_checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver
// Byte-serial frame receiver: header hunt, device check, length, payload
// and a CRC-8 (poly 0x31, init 0, msb first) verdict at frame end.
// ----------------------------------------------------------------------------
// One received byte gives exactly one result word. A byte is taken into an
// input register, and from there the frame state and the CRC are updated
// by a combinational eight-step CRC network while the result is written
// to the output register. The block sustains one byte per clock while the
// result side takes every word; the result word is held in the output
// register until it is taken. While a result waits, one more byte can
// still be taken into an empty input register; after that the input
// stalls until the result is taken. Payload bytes are reported as they
// arrive and are tentative until frame_done with crc_ok. camera_ready is sticky until reset.
// Configuration writes take effect at once and are meant for idle periods.
module crc8_checked_frame_receiver
	import crc8fr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [7:0]         cfg_data,
	// received bytes
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// results
	output logic               out_valid,
	input  logic               out_ready,
	output logic               payload_valid,
	output logic [7:0]         payload_byte,
	output logic [7:0]         payload_index,
	output logic               frame_done,
	output logic               crc_ok,
	output logic [3:0]         command_id,
	output logic [7:0]         payload_length,
	output logic               camera_ready
);

	// configuration registers
	logic [7:0] header_byte_q;
	logic [3:0] info_command_q;
	logic [7:0] min_info_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q     <= HEADER_BYTE_RST;
			info_command_q    <= INFO_COMMAND_RST;
			min_info_length_q <= MIN_INFO_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_BYTE:     header_byte_q     <= cfg_data;
				CFG_INFO_COMMAND:    info_command_q    <= cfg_data[3:0];
				CFG_MIN_INFO_LENGTH: min_info_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake and stage control
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       advance;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// frame state
	phase_t     phase_q;
	logic [7:0] data_count_q;
	logic [7:0] frame_length_q;
	logic [7:0] running_crc_q;
	logic [3:0] frame_command_q;
	logic       ready_flag_q;

	phase_t     phase_d;
	logic [7:0] data_count_d;
	logic [7:0] frame_length_d;
	logic [7:0] running_crc_d;
	logic [3:0] frame_command_d;
	logic       ready_flag_d;
	logic       pv_d;
	logic [7:0] pb_d;
	logic [7:0] pi_d;
	logic       fd_d;
	logic       ok_d;
	logic [7:0] crc_step;
	logic [7:0] count_inc;

	assign crc_step  = crc8_update(running_crc_q, rx_byte_s1);
	assign count_inc = data_count_q + 8'd1;

	// next state and result word for the byte in the input register
	always_comb begin
		phase_d         = phase_q;
		data_count_d    = data_count_q;
		frame_length_d  = frame_length_q;
		running_crc_d   = running_crc_q;
		frame_command_d = frame_command_q;
		ready_flag_d    = ready_flag_q;
		pv_d            = 1'b0;
		pb_d            = 8'd0;
		pi_d            = 8'd0;
		fd_d            = 1'b0;
		ok_d            = 1'b0;
		unique case (phase_q)
			PH_COMMAND: begin
				if (rx_byte_s1[7:4] == CAMERA_DEVICE) begin
					frame_command_d = rx_byte_s1[3:0];
					running_crc_d   = crc_step;
					phase_d         = PH_LENGTH;
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_LENGTH: begin
				frame_length_d = rx_byte_s1;
				running_crc_d  = crc_step;
				data_count_d   = 8'd0;
				phase_d        = (rx_byte_s1 == 8'd0) ? PH_CRC : PH_DATA;
			end
			PH_DATA: begin
				pv_d          = 1'b1;
				pb_d          = rx_byte_s1;
				pi_d          = data_count_q;
				running_crc_d = crc_step;
				data_count_d  = count_inc;
				if (count_inc == frame_length_q) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				fd_d    = 1'b1;
				phase_d = PH_HEADER;
				if (running_crc_q == rx_byte_s1) begin
					ok_d = 1'b1;
					if (frame_command_q == info_command_q
					    && frame_length_q >= min_info_length_q) begin
						ready_flag_d = 1'b1;
					end
				end
			end
			default: begin
				// header hunt, also the fallback for codes that are not a phase
				if (rx_byte_s1 == header_byte_q) begin
					running_crc_d = crc8_update(CRC_INIT, rx_byte_s1);
					data_count_d  = 8'd0;
					phase_d       = PH_COMMAND;
				end else begin
					phase_d = PH_HEADER;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			data_count_q    <= 8'd0;
			frame_length_q  <= 8'd0;
			running_crc_q   <= CRC_INIT;
			frame_command_q <= 4'd0;
			ready_flag_q    <= 1'b0;
		end else if (advance) begin
			phase_q         <= phase_d;
			data_count_q    <= data_count_d;
			frame_length_q  <= frame_length_d;
			running_crc_q   <= running_crc_d;
			frame_command_q <= frame_command_d;
			ready_flag_q    <= ready_flag_d;
		end
	end

	// result register
	logic       pv_q;
	logic [7:0] pb_q;
	logic [7:0] pi_q;
	logic       fd_q;
	logic       ok_q;
	logic [3:0] cmd_q;
	logic [7:0] len_q;
	logic       rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pv_q  <= pv_d;
			pb_q  <= pb_d;
			pi_q  <= pi_d;
			fd_q  <= fd_d;
			ok_q  <= ok_d;
			cmd_q <= frame_command_d;
			len_q <= frame_length_d;
			rdy_q <= ready_flag_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_valid  = pv_q;
	assign payload_byte   = pb_q;
	assign payload_index  = pi_q;
	assign frame_done     = fd_q;
	assign crc_ok         = ok_q;
	assign command_id     = cmd_q;
	assign payload_length = len_q;
	assign camera_ready   = rdy_q;

	// checks
	a_word_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(pv_q && fd_q))
		else $error("payload word and frame end word at once");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ok_q) |-> fd_q)
		else $error("crc_ok without frame_done");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_flag_q |=> ready_flag_q)
		else $error("camera ready flag cleared");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (data_count_q < frame_length_q))
		else $error("payload count ran past frame length");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

endmodule

// ===== verif/crc8_checked_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_tb
// Feeds received bytes to the frame receiver and checks every result word
// against a cycle-free model of the frame parser and its CRC-8. A short
// table of hand-picked bytes comes first. Random frames follow under four
// register settings, with random gaps on the byte side and random stalls
// on the result side. The last setting runs with neither.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_tb;
	import crc8fr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_ROWS    = 23;

	// one result word, in port order
	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_done;
		logic       crc_ok;
		logic [3:0] command_id;
		logic [7:0] payload_length;
		logic       camera_ready;
	} frame_word_t;

	// how a table row picks its byte
	typedef enum logic [1:0] {
		BYTE_AS_IS,
		CRC_GOOD,
		CRC_BAD
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  value;
		logic        fixed;
		frame_word_t want;
	} stim_row_t;

	localparam frame_word_t QUIET_WORD = '0;

	// hand-picked bytes; words typed in only where they are plain to see
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		'{BYTE_AS_IS, 8'h00, 1'b1, QUIET_WORD},  // not a header after reset
		'{BYTE_AS_IS, 8'hFF, 1'b1, QUIET_WORD},
		'{BYTE_AS_IS, 8'h55, 1'b1, QUIET_WORD},  // header
		'{BYTE_AS_IS, 8'h55, 1'b1, QUIET_WORD},  // wrong device, not a header
		'{BYTE_AS_IS, 8'h20, 1'b1, QUIET_WORD},  // ignored while hunting
		'{BYTE_AS_IS, 8'h55, 1'b1, QUIET_WORD},
		'{BYTE_AS_IS, 8'h3F, 1'b1, QUIET_WORD},  // wrong device
		'{BYTE_AS_IS, 8'h55, 1'b1, QUIET_WORD},
		'{BYTE_AS_IS, 8'h20, 1'b1, QUIET_WORD},  // info command
		'{BYTE_AS_IS, 8'h00, 1'b1, QUIET_WORD},  // zero length
		'{CRC_GOOD,   8'h00, 1'b1,
			'{1'b0, 8'h00, 8'd0, 1'b1, 1'b1, 4'h0, 8'd0, 1'b0}},
		'{BYTE_AS_IS, 8'h55, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'h2F, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'h02, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'hFF, 1'b1,
			'{1'b1, 8'hFF, 8'd0, 1'b0, 1'b0, 4'hF, 8'd2, 1'b0}},
		'{BYTE_AS_IS, 8'h00, 1'b0, QUIET_WORD},
		'{CRC_BAD,    8'h00, 1'b1,
			'{1'b0, 8'h00, 8'd0, 1'b1, 1'b0, 4'hF, 8'd2, 1'b0}},
		'{BYTE_AS_IS, 8'h55, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'h21, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'h01, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'hA5, 1'b0, QUIET_WORD},
		'{CRC_GOOD,   8'h00, 1'b0, QUIET_WORD},
		'{BYTE_AS_IS, 8'h7E, 1'b0, QUIET_WORD}   // held command and length
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [7:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               payload_valid;
	logic [7:0]         payload_byte;
	logic [7:0]         payload_index;
	logic               frame_done;
	logic               crc_ok;
	logic [3:0]         command_id;
	logic [7:0]         payload_length;
	logic               camera_ready;

	crc8_checked_frame_receiver i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.frame_done     (frame_done),
		.crc_ok         (crc_ok),
		.command_id     (command_id),
		.payload_length (payload_length),
		.camera_ready   (camera_ready)
	);

	always #4 clk = ~clk;

	// model copy of the registers
	logic [7:0] hdr_cfg     = HEADER_BYTE_RST;
	logic [3:0] info_cfg    = INFO_COMMAND_RST;
	logic [7:0] min_len_cfg = MIN_INFO_LENGTH_RST;

	// model copy of the frame state
	phase_t     rx_phase = PH_HEADER;
	logic [7:0] rx_count = '0;
	logic [7:0] rx_len   = '0;
	logic [7:0] rx_crc   = CRC_INIT;
	logic [3:0] rx_cmd   = '0;
	logic       rx_ready = 1'b0;

	frame_word_t awaited_words [$];
	int          bad_words  = 0;
	int          bytes_sent = 0;
	int          quiet      = 0;
	bit          gaps_on    = 1'b1;

	// crc-8, poly 0x31, msb first
	function automatic logic [7:0] crc8_of(logic [7:0] crc, logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	// advance the frame state by one byte and return its result word
	function automatic frame_word_t frame_word_for(logic [7:0] b);
		frame_word_t w;
		w = '0;
		case (rx_phase)
			PH_COMMAND: begin
				if (b[7:4] == CAMERA_DEVICE) begin
					rx_cmd   = b[3:0];
					rx_crc   = crc8_of(rx_crc, b);
					rx_phase = PH_LENGTH;
				end else begin
					rx_phase = PH_HEADER;
				end
			end
			PH_LENGTH: begin
				rx_len   = b;
				rx_crc   = crc8_of(rx_crc, b);
				rx_count = '0;
				rx_phase = (b == 8'd0) ? PH_CRC : PH_DATA;
			end
			PH_DATA: begin
				w.payload_valid = 1'b1;
				w.payload_byte  = b;
				w.payload_index = rx_count;
				rx_crc   = crc8_of(rx_crc, b);
				rx_count = rx_count + 8'd1;
				if (rx_count == rx_len) rx_phase = PH_CRC;
			end
			PH_CRC: begin
				w.frame_done = 1'b1;
				if (rx_crc == b) begin
					w.crc_ok = 1'b1;
					if (rx_cmd == info_cfg && rx_len >= min_len_cfg) rx_ready = 1'b1;
				end
				rx_phase = PH_HEADER;
			end
			default: begin
				if (b == hdr_cfg) begin
					rx_crc   = crc8_of(CRC_INIT, b);
					rx_count = '0;
					rx_phase = PH_COMMAND;
				end else begin
					rx_phase = PH_HEADER;
				end
			end
		endcase
		w.command_id     = rx_cmd;
		w.payload_length = rx_len;
		w.camera_ready   = rx_ready;
		return w;
	endfunction

	function automatic string word_text(frame_word_t w);
		return $sformatf("pv=%0b byte=%02h idx=%0d done=%0b ok=%0b cmd=%h len=%0d rdy=%0b",
			w.payload_valid, w.payload_byte, w.payload_index, w.frame_done,
			w.crc_ok, w.command_id, w.payload_length, w.camera_ready);
	endfunction

	// send one byte, with an optional gap ahead of it, and record its word
	task automatic push_byte(input logic [7:0] b, input logic fixed, input frame_word_t want);
		frame_word_t w;
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		w = frame_word_for(b);
		awaited_words.push_back(fixed ? want : w);
		bytes_sent++;
	endtask

	task automatic push_random(input logic [7:0] b);
		push_byte(b, 1'b0, QUIET_WORD);
	endtask

	// one frame: mostly well formed, sometimes noise, aborted or cut short
	task automatic send_frame();
		logic [7:0] cmd_b;
		logic [7:0] len_b;
		int         pick;
		int         cut;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) push_random(8'($urandom_range(0, 255)));
		end
		push_random(hdr_cfg);
		// wrong device aborts the frame
		if ($urandom_range(0, 9) == 0) begin
			cmd_b = 8'($urandom_range(0, 255));
			if (cmd_b[7:4] == CAMERA_DEVICE) cmd_b[7] = ~cmd_b[7];
			push_random(cmd_b);
			return;
		end
		cmd_b = {CAMERA_DEVICE,
			($urandom_range(0, 2) == 0) ? info_cfg : 4'($urandom_range(0, 15))};
		push_random(cmd_b);
		// mostly short payloads, now and then the longest
		pick = $urandom_range(0, 99);
		if (pick < 8) len_b = 8'd0;
		else if (pick < 60) len_b = 8'($urandom_range(1, 6));
		else if (pick < 80) len_b = 8'($urandom_range(7, 40));
		else if (pick < 88) len_b = min_len_cfg - 8'($urandom_range(0, 1));
		else if (pick < 97) len_b = 8'($urandom_range(0, 255));
		else len_b = 8'd255;
		push_random(len_b);
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len_b) : -1;
		for (int i = 0; i < len_b; i++) begin
			if (i == cut) return;
			push_random(8'($urandom_range(0, 255)));
		end
		if (cut == int'(len_b)) return;
		// check byte: mostly right, some off by one bit, some random
		pick = $urandom_range(0, 9);
		if (pick < 8) push_random(rx_crc);
		else if (pick == 8) push_random(rx_crc ^ (8'd1 << $urandom_range(0, 7)));
		else push_random(8'($urandom_range(0, 255)));
	endtask

	task automatic random_part(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count) send_frame();
	endtask

	// stop sending and let every awaited word come back
	task automatic drain();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] hdr, input logic [3:0] info,
			input logic [7:0] min_len);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HEADER_BYTE;
		cfg_data  <= hdr;
		@(posedge clk);
		cfg_index <= CFG_INFO_COMMAND;
		cfg_data  <= {4'h0, info};
		@(posedge clk);
		cfg_index <= CFG_MIN_INFO_LENGTH;
		cfg_data  <= min_len;
		@(posedge clk);
		cfg_we      <= 1'b0;
		hdr_cfg     = hdr;
		info_cfg    = info;
		min_len_cfg = min_len;
	endtask

	// result side: check each accepted word, then pick the next ready
	int   stall_left = 0;
	logic ready_next;
	always @(posedge clk) begin
		frame_word_t got;
		frame_word_t want;
		got = {payload_valid, payload_byte, payload_index, frame_done, crc_ok,
			command_id, payload_length, camera_ready};
		if (out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				bad_words++;
				if (bad_words <= 10) $display("error: word with none awaited: %s", word_text(got));
			end else begin
				want = awaited_words.pop_front();
				if (got.payload_valid !== want.payload_valid
						|| got.payload_byte !== want.payload_byte
						|| got.payload_index !== want.payload_index
						|| got.frame_done !== want.frame_done
						|| got.crc_ok !== want.crc_ok
						|| got.command_id !== want.command_id
						|| got.payload_length !== want.payload_length
						|| got.camera_ready !== want.camera_ready) begin
					bad_words++;
					if (bad_words <= 10) begin
						$display("error at %0t ns: wrong result word", $realtime);
						$display("  want %s", word_text(want));
						$display("  got  %s", word_text(got));
					end
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			ready_next = 1'b0;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 13);
			ready_next = 1'b0;
		end else begin
			ready_next = 1'b1;
		end
		out_ready <= ready_next;
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("crc8_checked_frame_receiver: mismatch");
			$finish;
		end
	end

	initial begin
		stim_row_t  row;
		logic [7:0] b;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table walk under reset settings
		for (int k = 0; k < NUM_ROWS; k++) begin
			row = DIRECTED[k];
			case (row.kind)
				CRC_GOOD: b = rx_crc;
				CRC_BAD:  b = rx_crc ^ 8'h01;
				default:  b = row.value;
			endcase
			push_byte(b, row.fixed, row.want);
		end
		drain();

		// random frames under several settings, extremes first
		load_settings(8'h00, 4'hF, 8'hFF);
		random_part(440);
		drain();
		load_settings(8'hFF, 4'h0, 8'h00);
		random_part(440);
		drain();
		load_settings(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 8)));
		random_part(440);
		drain();

		// last stretch runs without gaps or stalls
		gaps_on = 1'b0;
		load_settings(HEADER_BYTE_RST, 4'($urandom_range(0, 15)), MIN_INFO_LENGTH_RST);
		random_part(430);
		drain();

		if (bad_words == 0 && awaited_words.size() == 0) begin
			$display("crc8_checked_frame_receiver: match");
		end else begin
			$display("crc8_checked_frame_receiver: mismatch");
		end
		$finish;
	end

endmodule
